>>> design/dee_pkg.sv
// Package for the delta entropy estimator: history entry type, table size
// and the bit-length function. No dependencies.
package dee_pkg;

    localparam int SOURCES    = 16;
    localparam int IDX_W      = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam int SAMPLE_W   = 32;
    localparam int SRC_ID_W   = 4;
    localparam int ENTROPY_W  = 6;
    localparam int OUT_DATA_W = 8;

    typedef struct packed {
        logic [31:0] sample;
        logic [31:0] d1;
        logic [32:0] d2;
    } hist_t;

    // Bit length of a 32-bit value, 0 for zero, 32 for top bit set.
    function automatic logic [ENTROPY_W-1:0] bit_length(input logic [31:0] val);
        logic [31:0]          v;
        logic [ENTROPY_W-1:0] len;
        begin
            v   = val;
            len = 6'd32;
            if (v == 32'd0)
            begin
                len = 6'd0;
            end
            else
            begin
                if ((v & 32'hFFFF_0000) == 32'd0)
                begin
                    len = len - 6'd16;
                    v   = v << 16;
                end
                if ((v & 32'hFF00_0000) == 32'd0)
                begin
                    len = len - 6'd8;
                    v   = v << 8;
                end
                if ((v & 32'hF000_0000) == 32'd0)
                begin
                    len = len - 6'd4;
                    v   = v << 4;
                end
                if ((v & 32'hC000_0000) == 32'd0)
                begin
                    len = len - 6'd2;
                    v   = v << 2;
                end
                if ((v & 32'h8000_0000) == 32'd0)
                begin
                    len = len - 6'd1;
                end
            end
            return len;
        end
    endfunction

endpackage

>>> design/dee_history.sv
// Per-source history table (last sample, last d1, last d2) in flip-flops,
// cleared at reset. Depends on dee_pkg.
module dee_history
    import dee_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] idx,
    output hist_t            rd_entry,
    input  logic             wr_en,
    input  hist_t            wr_entry
);

    hist_t table_reg [SOURCES];

    assign rd_entry = table_reg[idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SOURCES; i++)
            begin
                table_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            table_reg[idx] <= wr_entry;
        end
    end

endmodule

>>> design/dee_delta.sv
// Delta datapath: first, second and third deltas, smallest magnitude and its
// bit length; also forms the updated history entry. Depends on dee_pkg.
module dee_delta
    import dee_pkg::*;
(
    input  logic [SAMPLE_W-1:0]  sample,
    input  hist_t                prev,
    output hist_t                next,
    output logic [ENTROPY_W-1:0] entropy_bits
);

    logic        [31:0] d1u;
    logic signed [32:0] d2;
    logic signed [33:0] d3;
    logic        [32:0] abs2;
    logic        [33:0] abs3;
    logic        [33:0] m1;
    logic        [33:0] m2;
    logic        [33:0] m3;

    always_comb
    begin
        d1u  = sample - prev.sample;
        d2   = $signed({1'b0, d1u}) - $signed({1'b0, prev.d1});
        d3   = $signed({d2[32], d2}) - $signed({prev.d2[32], prev.d2});
        abs2 = d2[32] ? 33'(-d2) : 33'(d2);
        abs3 = d3[33] ? 34'(-d3) : 34'(d3);

        m1 = {2'b00, d1u};
        m2 = ({1'b0, abs2} < m1) ? {1'b0, abs2} : m1;
        m3 = (abs3 < m2) ? abs3 : m2;

        entropy_bits = bit_length(m3[31:0]);

        next.sample = sample;
        next.d1     = d1u;
        next.d2     = d2;
    end

endmodule

>>> design/delta_entropy_estimator.sv
// Top level of the delta entropy estimator: stream ports, input and result
// registers, history table and delta datapath. Depends on dee_pkg, dee_history, dee_delta.
//
// Takes one beat per cycle: a 32-bit sample (tdata) and a source index (tuser,
// reduced modulo SOURCES). The result, the bit length (0..32) of the smallest of
// |d1|, |d2|, |d3| for that source, is computed from the input register and
// offered from the result register. The rate of one beat per cycle is set by
// the history table, which is read, updated and written back between the
// input and result registers, so back-to-back beats on one source see each
// other's history.
// The input stalls only while both registers hold a beat and m_tready is low.
// The table is flip-flops cleared directly by reset; no clearing pass is needed.
module delta_entropy_estimator
    import dee_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,   // [31:0] sample
    input  logic [SRC_ID_W-1:0]   s_tuser,   // [3:0] source_id
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // [5:0] entropy_bits, [7:6] zero
);

    logic                 in_valid_reg;
    logic [SAMPLE_W-1:0]  sample_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic                 out_valid_reg;
    logic [ENTROPY_W-1:0] entropy_reg;
    logic                 advance;
    logic                 in_take;
    hist_t                prev_entry;
    hist_t                next_entry;
    logic [ENTROPY_W-1:0] entropy_next;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || !out_valid_reg || m_tready;
    assign in_take  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            sample_reg <= s_tdata;
            idx_reg    <= IDX_W'(s_tuser % SOURCES);
        end
        if (advance)
        begin
            entropy_reg <= entropy_next;
        end
    end

    dee_history u_history (
        .clk      (clk),
        .rst_n    (rst_n),
        .idx      (idx_reg),
        .rd_entry (prev_entry),
        .wr_en    (advance),
        .wr_entry (next_entry)
    );

    dee_delta u_delta (
        .sample       (sample_reg),
        .prev         (prev_entry),
        .next         (next_entry),
        .entropy_bits (entropy_next)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - ENTROPY_W){1'b0}}, entropy_reg};

    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[5:0] <= 6'd32))
        else $error("entropy result above 32");

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("pending beat did not reach result register");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready && !in_valid_reg) |=> $stable(entropy_reg))
        else $error("result changed while stalled");

endmodule

>>> test/tb.sv
// Self-checking testbench for delta_entropy_estimator: drives sample beats,
// predicts the entropy estimate from a per-source delta history, checks results.
// Depends on dee_pkg and the delta_entropy_estimator RTL.
module tb;
    import dee_pkg::*;

    localparam int TIMEOUT_CYCLES = 300000;
    localparam int MAX_REPORTS    = 10;
    localparam int RX_HOLD_CYCLES = 80;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata;
    logic [SRC_ID_W-1:0]   s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    delta_entropy_estimator uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // predictor history, one entry per source
    logic [31:0]        hist_sample [SOURCES];
    logic [31:0]        hist_d1     [SOURCES];
    logic signed [32:0] hist_d2     [SOURCES];

    logic [OUT_DATA_W-1:0] expected_entropy_q[$];

    int mismatch_cnt  = 0;
    int cycle_cnt     = 0;
    int tx_idle_pct;
    int rx_idle_pct;
    int rx_hold       = 0;
    int rx_hold_reqs;
    int rx_hold_taken = 0;

    // stimulus generator state for timer-like sources
    logic [31:0] tick_last   [SOURCES];
    logic [31:0] tick_period [SOURCES];

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic logic [ENTROPY_W-1:0] msb_length(input logic [31:0] v);
        int n;
        n = 0;
        for (int i = 0; i < 32; i++)
        begin
            if (v[i])
            begin
                n = i + 1;
            end
        end
        return n[ENTROPY_W-1:0];
    endfunction

    function automatic void predict_entropy(input logic [31:0] smp, input logic [3:0] src);
        int unsigned idx;
        logic [31:0] d1u;
        longint      d1;
        longint      d2;
        longint      d3;
        longint      smallest;
        logic [ENTROPY_W-1:0] bits;
        idx = src % SOURCES;
        d1u = smp - hist_sample[idx];
        d1  = longint'(d1u);
        d2  = d1 - longint'(hist_d1[idx]);
        d3  = d2 - longint'(hist_d2[idx]);
        hist_sample[idx] = smp;
        hist_d1[idx]     = d1u;
        hist_d2[idx]     = d2[32:0];
        if (d2 < 0)
        begin
            d2 = -d2;
        end
        if (d3 < 0)
        begin
            d3 = -d3;
        end
        smallest = d1;
        if (d2 < smallest)
        begin
            smallest = d2;
        end
        if (d3 < smallest)
        begin
            smallest = d3;
        end
        bits = msb_length(smallest[31:0]);
        expected_entropy_q.push_back({{(OUT_DATA_W-ENTROPY_W){1'b0}}, bits});
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            predict_entropy(s_tdata, s_tuser);
        end
    end

    always @(posedge clk)
    begin
        logic [OUT_DATA_W-1:0] exp_beat;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_entropy_q.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                begin
                    $display("unexpected result beat: got %0d", m_tdata);
                end
            end
            else
            begin
                exp_beat = expected_entropy_q.pop_front();
                if (m_tdata !== exp_beat)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                    begin
                        $display("entropy mismatch: expected %0d (pad %b), got %0d (pad %b)",
                                 exp_beat[ENTROPY_W-1:0], exp_beat[OUT_DATA_W-1:ENTROPY_W],
                                 m_tdata[ENTROPY_W-1:0], m_tdata[OUT_DATA_W-1:ENTROPY_W]);
                    end
                end
            end
        end
    end

    // receiver; a hold request from the test starts a long stretch of m_tready low
    always @(negedge clk)
    begin
        if (rx_hold_taken != rx_hold_reqs)
        begin
            rx_hold_taken <= rx_hold_reqs;
            rx_hold       <= RX_HOLD_CYCLES - 1;
            m_tready      <= 1'b0;
        end
        else if (rx_hold > 0)
        begin
            m_tready <= 1'b0;
            rx_hold  <= rx_hold - 1;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > TIMEOUT_CYCLES)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_sample(input logic [31:0] smp, input logic [3:0] src);
        while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= src;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_entropy_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic send_tick(input logic [3:0] src);
        int w;
        logic [31:0] jitter;
        w = $urandom_range(0, 20);
        jitter = (w == 0) ? 32'd0 : ($urandom() >> (32 - w));
        if ($urandom_range(0, 1))
        begin
            jitter = -jitter;
        end
        tick_last[src] = tick_last[src] + tick_period[src] + jitter;
        send_sample(tick_last[src], src);
    endtask

    task automatic test_extremes();
        send_sample(32'h0000_0000, 4'd0);
        send_sample(32'hFFFF_FFFF, 4'd0);
        send_sample(32'hFFFF_FFFF, 4'd0);
        send_sample(32'h0000_0000, 4'd0);
        send_sample(32'h0000_0001, 4'd0);
        send_sample(32'h8000_0000, 4'd15);
        send_sample(32'h0000_0000, 4'd15);
        send_sample(32'h8000_0000, 4'd15);
        send_sample(32'h0000_0001, 4'd5);
        send_sample(32'h0000_0002, 4'd5);
        send_sample(32'h0000_0003, 4'd5);
        send_sample(32'h0000_0004, 4'd5);
        send_sample(32'h7FFF_FFFF, 4'd9);
        send_sample(32'hFFFF_FFFE, 4'd9);
        send_sample(32'h7FFF_FFFD, 4'd9);
        send_sample(32'hFFFF_FFFF, 4'd10);
        send_sample(32'h0000_FFFF, 4'd10);
        send_sample(32'hFFFF_0000, 4'd10);
        wait_drained();
    endtask

    task automatic test_random_noise();
        for (int i = 0; i < 150; i++)
        begin
            send_sample($urandom(), 4'($urandom_range(0, 15)));
        end
        wait_drained();
    endtask

    task automatic test_timer_sources();
        for (int s = 0; s < SOURCES; s++)
        begin
            tick_last[s]   = $urandom();
            tick_period[s] = $urandom() >> $urandom_range(0, 31);
        end
        for (int i = 0; i < 250; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_sample($urandom(), 4'($urandom_range(0, 15)));
            end
            else
            begin
                send_tick(4'($urandom_range(0, 15)));
            end
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        @(posedge clk);
        rx_hold_reqs++;
        @(negedge clk);
        for (int i = 0; i < 40; i++)
        begin
            send_tick(4'($urandom_range(0, 3)));
        end
        wait_drained();
    endtask

    task automatic test_full_rate();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (int i = 0; i < 100; i++)
        begin
            if (i % 2 == 0)
            begin
                send_tick(4'($urandom_range(0, 15)));
            end
            else
            begin
                send_sample($urandom(), 4'($urandom_range(0, 15)));
            end
        end
        tx_idle_pct = 14;
        rx_idle_pct = 14;
        wait_drained();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        tx_idle_pct  = 14;
        rx_idle_pct  = 14;
        rx_hold_reqs = 0;
        for (int s = 0; s < SOURCES; s++)
        begin
            hist_sample[s] = '0;
            hist_d1[s]     = '0;
            hist_d2[s]     = '0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_extremes();
        test_random_noise();
        test_timer_sources();
        test_backpressure();
        test_full_rate();

        repeat (10) @(negedge clk);
        if (mismatch_cnt == 0 && expected_entropy_q.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> delta_entropy_estimator.f
design/dee_pkg.sv
design/dee_history.sv
design/dee_delta.sv
design/delta_entropy_estimator.sv
test/tb.sv
